// ===== sv/piece_to_file_span_mapper_defines.svh =====
// Assertion macros shared by the piece to file span mapper.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef PIECE_TO_FILE_SPAN_MAPPER_DEFINES_SVH
`define PIECE_TO_FILE_SPAN_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTFSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTFSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ptfsm_pkg.sv =====
// Package for the piece to file span mapper: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package ptfsm_pkg;

	localparam int MAX_FILES = 16;
	localparam int IDX_W     = $clog2(MAX_FILES);
	localparam int LEN_W     = 40;
	localparam int END_W     = 44;
	localparam int PIDX_W    = 24;
	localparam int PLEN_W    = 25;
	localparam int FCNT_W    = 5;
	localparam int START_W   = PIDX_W + PLEN_W;

	localparam logic [PLEN_W-1:0] PLEN_MAX   = PLEN_W'(16777216);
	localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(262144);
	localparam logic [FCNT_W-1:0] FCNT_RESET = FCNT_W'(1);

	// Input item commands.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_MAP  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_PIECE_LENGTH = 1'b0;
	localparam logic REG_FILE_COUNT   = 1'b1;

	// Table read address selection.
	localparam logic [1:0] RA_PREV = 2'd0;
	localparam logic [1:0] RA_LAST = 2'd1;
	localparam logic [1:0] RA_IDX  = 2'd2;

	typedef struct packed {
		logic       capture;
		logic [1:0] ra_sel;
		logic       wr_en;
		logic       mul_en;
		logic       chk_en;
		logic       idx_clr;
		logic       idx_inc;
		logic       emit_init;
		logic       emit_seg;
		logic       emit_err;
	} dp_cmd_t;

	typedef struct packed {
		logic oor;
		logic scan_more;
		logic seg_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/ptfsm_dp.sv =====
// Datapath of the piece to file span mapper: file tables, piece arithmetic,
// segment walk and the output register. Depends on ptfsm_pkg.
module ptfsm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptfsm_pkg::dp_cmd_t           cmd,
	output ptfsm_pkg::dp_status_t        status,
	input  logic [ptfsm_pkg::PLEN_W-1:0] cfg_plen,
	input  logic [ptfsm_pkg::FCNT_W-1:0] cfg_fcnt,
	input  logic [ptfsm_pkg::IDX_W-1:0]  file_slot,
	input  logic [ptfsm_pkg::LEN_W-1:0]  file_length,
	input  logic [ptfsm_pkg::PIDX_W-1:0] piece_num,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ptfsm_pkg::IDX_W-1:0]  seg_file,
	output logic [ptfsm_pkg::LEN_W-1:0]  file_offset,
	output logic [ptfsm_pkg::PIDX_W-1:0] piece_offset,
	output logic [ptfsm_pkg::PLEN_W-1:0] byte_count,
	output logic                         last,
	output logic                         out_of_range
);
	import ptfsm_pkg::*;

	logic [LEN_W-1:0]   len_mem [MAX_FILES];
	logic [END_W-1:0]   end_mem [MAX_FILES];
	logic [LEN_W-1:0]   len_rd_q;
	logic [END_W-1:0]   end_rd_q;
	logic [IDX_W-1:0]   rd_addr;

	logic [IDX_W-1:0]   slot_q;
	logic [LEN_W-1:0]   flen_q;
	logic [PIDX_W-1:0]  pidx_q;
	logic [PLEN_W-1:0]  plen_q;
	logic [IDX_W-1:0]   n_last_q;
	logic [START_W-1:0] start_q;
	logic [END_W-1:0]   stop_q;
	logic [END_W-1:0]   prev_end_q;
	logic [END_W-1:0]   pos_file_q;
	logic [PLEN_W-1:0]  left_q;
	logic [PLEN_W-1:0]  pos_piece_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_d;
	logic               out_valid_q;

	logic [PLEN_W-1:0]  plen_eff;
	logic [FCNT_W-1:0]  n_last_eff;
	logic [END_W-1:0]   prev_end;
	logic [END_W-1:0]   new_end;
	logic [START_W-1:0] product;
	logic [START_W:0]   stop_sum;
	logic [END_W-1:0]   stop_d;
	logic [END_W-1:0]   begin_v;
	logic [LEN_W-1:0]   fleft;
	logic [PLEN_W-1:0]  cnt;

	// Zero piece length counts as one byte; above PLEN_MAX it saturates.
	always_comb begin
		if (cfg_plen == '0) begin
			plen_eff = PLEN_W'(1);
		end else if (cfg_plen > PLEN_MAX) begin
			plen_eff = PLEN_MAX;
		end else begin
			plen_eff = cfg_plen;
		end
		if (cfg_fcnt == '0) begin
			n_last_eff = '0;
		end else if (cfg_fcnt > FCNT_W'(MAX_FILES)) begin
			n_last_eff = FCNT_W'(MAX_FILES - 1);
		end else begin
			n_last_eff = cfg_fcnt - FCNT_W'(1);
		end
	end

	always_comb begin
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + IDX_W'(1);
		end else begin
			idx_d = idx_q;
		end
		case (cmd.ra_sel)
			RA_PREV: rd_addr = file_slot - IDX_W'(1);
			RA_LAST: rd_addr = n_last_q;
			default: rd_addr = idx_d;
		endcase
	end

	assign prev_end = (slot_q == '0) ? '0 : end_rd_q;
	assign new_end  = prev_end + END_W'(flen_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			len_mem[slot_q] <= flen_q;
			end_mem[slot_q] <= new_end;
		end
		len_rd_q <= len_mem[rd_addr];
		end_rd_q <= end_mem[rd_addr];
	end

	assign product  = pidx_q * plen_q;
	assign stop_sum = (START_W+1)'(start_q) + (START_W+1)'(plen_q);
	assign stop_d   = (stop_sum > (START_W+1)'(end_rd_q)) ? end_rd_q : stop_sum[END_W-1:0];
	assign begin_v  = (idx_q == '0) ? '0 : prev_end_q;

	// Bytes left in the current file, never negative.
	assign fleft = (END_W'(len_rd_q) > pos_file_q) ? LEN_W'(END_W'(len_rd_q) - pos_file_q) : '0;
	assign cnt   = (LEN_W'(left_q) > fleft) ? PLEN_W'(fleft) : left_q;

	assign status.oor       = start_q >= START_W'(end_rd_q);
	assign status.scan_more = (idx_q < n_last_q) && (START_W'(end_rd_q) <= start_q);
	assign status.seg_last  = (idx_q == n_last_q) || (end_rd_q >= stop_q)
		|| (k_q == IDX_W'(MAX_FILES - 1));
	assign status.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q   <= file_slot;
			flen_q   <= file_length;
			pidx_q   <= piece_num;
			plen_q   <= plen_eff;
			n_last_q <= n_last_eff[IDX_W-1:0];
		end
		if (cmd.mul_en) begin
			start_q <= product;
		end
		if (cmd.chk_en) begin
			stop_q <= stop_d;
		end
		idx_q <= idx_d;
		if (cmd.idx_inc) begin
			prev_end_q <= end_rd_q;
		end
		if (cmd.emit_init) begin
			pos_file_q  <= (start_q > START_W'(begin_v)) ?
				END_W'(start_q - START_W'(begin_v)) : '0;
			left_q      <= PLEN_W'(START_W'(stop_q) - start_q);
			pos_piece_q <= '0;
			k_q         <= '0;
		end else if (cmd.emit_seg) begin
			pos_file_q  <= '0;
			left_q      <= left_q - cnt;
			pos_piece_q <= pos_piece_q + cnt;
			k_q         <= k_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_seg || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_seg) begin
			seg_file     <= idx_q;
			file_offset  <= pos_file_q[LEN_W-1:0];
			piece_offset <= pos_piece_q[PIDX_W-1:0];
			byte_count   <= cnt;
			last         <= status.seg_last;
			out_of_range <= 1'b0;
		end else if (cmd.emit_err) begin
			seg_file     <= '0;
			file_offset  <= '0;
			piece_offset <= '0;
			byte_count   <= '0;
			last         <= 1'b1;
			out_of_range <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/ptfsm_ctrl.sv =====
// Controller state machine of the piece to file span mapper.
// Sequences loads, the piece arithmetic, the table scan and emission; uses ptfsm_pkg.
module ptfsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_cmd,
	output logic                  in_stall,
	input  ptfsm_pkg::dp_status_t status,
	output ptfsm_pkg::dp_cmd_t    cmd
);
	import ptfsm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LD_WR = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_ERR   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.ra_sel = RA_IDX;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.ra_sel = RA_PREV;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (in_cmd == CMD_LOAD) ? ST_LD_WR : ST_MUL;
				end
			end
			ST_LD_WR: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.ra_sel = RA_LAST;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk_en  = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = status.oor ? ST_ERR : ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_more) begin
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_seg = 1'b1;
					cmd.idx_inc  = 1'b1;
					if (status.seg_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/piece_to_file_span_mapper.sv =====
// Piece to file span mapper. A load item (cmd 0) makes one table read of the previous
// slot's end offset, then one write of the length and new end. A map item (cmd 1) forms
// the piece start product, then runs the total-length check, then scans the slots up to
// and including the first file holding the piece's first byte, then emits one segment at
// a time while the output side takes them. An out-of-range piece gives one error result
// after the check. The single read port of the file table is stepped through one slot a
// cycle by the scan, and by the segment walk while the output side takes its segments.
// Configuration sits at byte address 0 (piece_length) and 4 (file_count); the user must
// write it only while the block is idle, and the block itself does not enforce this.
module piece_to_file_span_mapper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [ptfsm_pkg::IDX_W-1:0]  file_slot,
	input  logic [ptfsm_pkg::LEN_W-1:0]  file_length,
	input  logic [ptfsm_pkg::PIDX_W-1:0] piece_num,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ptfsm_pkg::IDX_W-1:0]  seg_file,
	output logic [ptfsm_pkg::LEN_W-1:0]  file_offset,
	output logic [ptfsm_pkg::PIDX_W-1:0] piece_offset,
	output logic [ptfsm_pkg::PLEN_W-1:0] byte_count,
	output logic                         last,
	output logic                         out_of_range
);
	import ptfsm_pkg::*;
	`include "piece_to_file_span_mapper_defines.svh"

	logic [PLEN_W-1:0] piece_length_q;
	logic [FCNT_W-1:0] file_count_q;
	logic              cfg_wr;
	dp_cmd_t           dp_cmd;
	dp_status_t        dp_status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_length_q <= PLEN_RESET;
			file_count_q   <= FCNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PIECE_LENGTH: piece_length_q <= pwdata[PLEN_W-1:0];
				REG_FILE_COUNT:   file_count_q   <= pwdata[FCNT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PIECE_LENGTH: prdata = 32'(piece_length_q);
			REG_FILE_COUNT:   prdata = 32'(file_count_q);
			default:          prdata = '0;
		endcase
	end

	ptfsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_stall (in_stall),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	ptfsm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.cfg_plen     (piece_length_q),
		.cfg_fcnt     (file_count_q),
		.file_slot    (file_slot),
		.file_length  (file_length),
		.piece_num    (piece_num),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.seg_file     (seg_file),
		.file_offset  (file_offset),
		.piece_offset (piece_offset),
		.byte_count   (byte_count),
		.last         (last),
		.out_of_range (out_of_range)
	);

	// An error result is a single, empty, final transfer.
	`PTFSM_ASSERT_NOW(a_err_shape, out_valid && out_of_range, last && byte_count == '0 && seg_file == '0, "error result is not a single empty final transfer")
	// Every accepted item makes the block busy, so no second item is taken straight after it.
	`PTFSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block took items on consecutive cycles")
	// A non-final segment transfer is followed at once by the next segment.
	`PTFSM_ASSERT_NEXT(a_next_seg_follows, out_valid && !out_stall && !last, out_valid, "gap after a non-final segment")

endmodule
